// ===== rtl/core/sws_pkg.sv =====
`default_nettype none

package sws_pkg;

    // Ring depth per rate class.
    localparam int RING_DEPTH_DEF = 128;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_MAX_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_MAX_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_MIN_GAP_MS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_MIN_GAP_MS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN_HOLDOFF_MS = 3'd5;

    // Register values after reset.
    localparam logic [7:0]  HIGH_MAX_COUNT_RST  = 8'd99;
    localparam logic [7:0]  LOW_MAX_COUNT_RST   = 8'd19;
    localparam logic [15:0] HIGH_MIN_GAP_MS_RST = 16'd100;
    localparam logic [15:0] LOW_MIN_GAP_MS_RST  = 16'd1100;
    localparam logic [19:0] WINDOW_MS_RST       = 20'd32000;
    localparam logic [19:0] WARN_HOLDOFF_MS_RST = 20'd30000;

    // Refusal codes.
    localparam logic [1:0] REFUSE_NONE = 2'd0;
    localparam logic [1:0] REFUSE_FAST = 2'd1;
    localparam logic [1:0] REFUSE_MANY = 2'd2;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        high_rate;
    } t_req;

    typedef struct packed {
        logic       accepted;
        logic [1:0] refusal;
        logic       warn;
    } t_res;

endpackage

`default_nettype wire

// ===== rtl/core/sliding_window_send_limiter.sv =====
`default_nettype none

// Send-rate limiter with a high-rate and a low-rate class. Each request beat carries a
// millisecond timestamp and a class bit and yields one result beat: accepted, or refused as
// too fast (closer than the class minimum gap to the last accepted send) or as too many
// (class window already holds its maximum), plus a warn flag rate-limited by a holdoff
// shared across classes. All time comparisons use the 32-bit wrapped difference. Accepted
// timestamps live in one synchronous single-port-read memory holding a ring per class. One
// item is handled at a time: a request goes from idle to the gap check and, unless it is
// refused as too fast, on to the expiry state, which holds while stored timestamps age out
// of the window, since expired entries are popped one memory read per cycle. The done state
// then moves the result to the output register once that is free, and the block goes back
// to idle, where the next request can be taken. A new request
// is taken only once the previous result has moved to the output register, so a stalled
// output holds off the input. Configuration is written through a plain write port and must
// only change while the block is idle.
module sliding_window_send_limiter #(
    parameter int RING_DEPTH = sws_pkg::RING_DEPTH_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  sws_pkg::t_req                  i_in_req,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output sws_pkg::t_res                  o_out_res,
    input  wire                            i_cfg_we,
    input  wire [sws_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [sws_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int IDX_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W     = $clog2(RING_DEPTH + 1);
    localparam int SUM_W     = CNT_W + 1;
    localparam int CMP_W     = (CNT_W > 8) ? CNT_W : 8;
    localparam int MEM_DEPTH = 2 * (2 ** IDX_W);

    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(RING_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(RING_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_GAP  = 4'b0010,
        S_EXP  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] r;
        r = (s >= DEPTH_SUM) ? (s - DEPTH_SUM) : s;
        return r[IDX_W-1:0];
    endfunction

    t_state r_state;

    // Configuration registers.
    logic [7:0]  r_high_max;
    logic [7:0]  r_low_max;
    logic [15:0] r_high_gap;
    logic [15:0] r_low_gap;
    logic [19:0] r_window;
    logic [19:0] r_holdoff;

    // Per-class ring pointers; index 1 is the high-rate class.
    logic [IDX_W-1:0] r_head  [2];
    logic [CNT_W-1:0] r_count [2];

    logic [31:0] r_last_fast;
    logic [31:0] r_last_many;
    logic [1:0]  r_seen;

    logic [31:0]   r_now;
    logic          r_cls;
    sws_pkg::t_res r_res;
    sws_pkg::t_res r_out_res;
    logic          r_out_valid;

    logic [31:0] r_ring [MEM_DEPTH];
    logic [31:0] r_rd_data;

    logic             sel_cls;
    logic [IDX_W-1:0] cur_head;
    logic [CNT_W-1:0] cur_count;
    logic [IDX_W-1:0] newest_idx;
    logic [IDX_W-1:0] next_head;
    logic [IDX_W-1:0] tail_idx;
    logic [IDX_W-1:0] rd_idx;
    logic [31:0]      age;
    logic [15:0]      cur_gap;
    logic [7:0]       cur_max;
    logic             too_fast;
    logic             pop;
    logic             full;
    logic             fast_warn_ok;
    logic             many_warn_ok;
    logic             mem_we;
    logic             out_free;

    always_comb begin
        sel_cls   = (r_state == S_IDLE) ? i_in_req.high_rate : r_cls;
        cur_head  = r_head[sel_cls];
        cur_count = r_count[sel_cls];

        newest_idx = (cur_count == '0) ? cur_head
                   : wrap_idx(SUM_W'(cur_head) + SUM_W'(cur_count) - SUM_W'(1));
        next_head  = wrap_idx(SUM_W'(cur_head) + SUM_W'(1));
        tail_idx   = wrap_idx(SUM_W'(cur_head) + SUM_W'(cur_count));

        age     = r_now - r_rd_data;
        cur_gap = r_cls ? r_high_gap : r_low_gap;
        cur_max = r_cls ? r_high_max : r_low_max;

        too_fast = (cur_count != '0) && (age < {16'd0, cur_gap});
        pop      = (cur_count != '0) && (age > {12'd0, r_window});
        // A maximum above the ring depth acts as the depth.
        full     = (CMP_W'(cur_count) >= CMP_W'(cur_max)) || (cur_count == DEPTH_CNT);

        fast_warn_ok = !r_seen[0] || ((r_now - r_last_fast) > {12'd0, r_holdoff});
        many_warn_ok = !r_seen[1] || ((r_now - r_last_many) > {12'd0, r_holdoff});

        mem_we   = (r_state == S_EXP) && !pop && !full;
        out_free = !r_out_valid || !i_out_stall;

        unique case (r_state)
            S_IDLE:  rd_idx = newest_idx;
            S_GAP:   rd_idx = cur_head;
            S_EXP:   rd_idx = next_head;
            default: rd_idx = cur_head;
        endcase
    end

    // The write of an accepted timestamp happens in the last expiry cycle; the next read whose data
    // is used is issued in idle, after the done state, so used reads never race a write to the same entry.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ring[{r_cls, tail_idx}] <= r_now;
        end
        r_rd_data <= r_ring[{sel_cls, rd_idx}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_high_max  <= sws_pkg::HIGH_MAX_COUNT_RST;
            r_low_max   <= sws_pkg::LOW_MAX_COUNT_RST;
            r_high_gap  <= sws_pkg::HIGH_MIN_GAP_MS_RST;
            r_low_gap   <= sws_pkg::LOW_MIN_GAP_MS_RST;
            r_window    <= sws_pkg::WINDOW_MS_RST;
            r_holdoff   <= sws_pkg::WARN_HOLDOFF_MS_RST;
            r_head[0]   <= '0;
            r_head[1]   <= '0;
            r_count[0]  <= '0;
            r_count[1]  <= '0;
            r_last_fast <= '0;
            r_last_many <= '0;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    sws_pkg::CFG_HIGH_MAX_COUNT:  r_high_max <= i_cfg_data[7:0];
                    sws_pkg::CFG_LOW_MAX_COUNT:   r_low_max  <= i_cfg_data[7:0];
                    sws_pkg::CFG_HIGH_MIN_GAP_MS: r_high_gap <= i_cfg_data[15:0];
                    sws_pkg::CFG_LOW_MIN_GAP_MS:  r_low_gap  <= i_cfg_data[15:0];
                    sws_pkg::CFG_WINDOW_MS:       r_window   <= i_cfg_data;
                    sws_pkg::CFG_WARN_HOLDOFF_MS: r_holdoff  <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_GAP;
                    end
                end
                S_GAP: begin
                    if (too_fast) begin
                        r_res.accepted <= 1'b0;
                        r_res.refusal  <= sws_pkg::REFUSE_FAST;
                        r_res.warn     <= fast_warn_ok;
                        if (fast_warn_ok) begin
                            r_last_fast <= r_now;
                            r_seen[0]   <= 1'b1;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_EXP;
                    end
                end
                S_EXP: begin
                    if (pop) begin
                        r_head[r_cls]  <= next_head;
                        r_count[r_cls] <= cur_count - CNT_W'(1);
                    end else if (full) begin
                        r_res.accepted <= 1'b0;
                        r_res.refusal  <= sws_pkg::REFUSE_MANY;
                        r_res.warn     <= many_warn_ok;
                        if (many_warn_ok) begin
                            r_last_many <= r_now;
                            r_seen[1]   <= 1'b1;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_count[r_cls] <= cur_count + CNT_W'(1);
                        r_res.accepted <= 1'b1;
                        r_res.refusal  <= sws_pkg::REFUSE_NONE;
                        r_res.warn     <= 1'b0;
                        r_state        <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_now <= i_in_req.now_ms;
            r_cls <= i_in_req.high_rate;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_res <= r_res;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count[0] <= DEPTH_CNT) && (r_count[1] <= DEPTH_CNT))
        else $error("ring count exceeds ring depth");

    a_accept_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_res.accepted) |->
        (o_out_res.refusal == sws_pkg::REFUSE_NONE) && !o_out_res.warn)
        else $error("accepted result carries a refusal or warning");

    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (r_state == S_IDLE) && o_out_valid)
        else $error("finished result not moved to output register");

    a_write_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> !full && (cur_count < DEPTH_CNT))
        else $error("ring written while full");

    a_seen_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seen[0] |=> r_seen[0]) and (r_seen[1] |=> r_seen[1]))
        else $error("warning seen flag cleared");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int RING_DEPTH = sws_pkg::RING_DEPTH_DEF;
    localparam int IDX_W      = sws_pkg::CFG_IDX_W;
    localparam int DATA_W     = sws_pkg::CFG_DATA_W;
    localparam int KIND_FAST  = 0;
    localparam int KIND_MANY  = 1;
    localparam int PHASES     = 8;
    localparam int FILL_PHASE = 2;

    // Indexes past the last register; writes to them must change nothing.
    localparam logic [IDX_W-1:0] CFG_SPARE_FIRST = sws_pkg::CFG_WARN_HOLDOFF_MS + 1'b1;
    localparam logic [IDX_W-1:0] CFG_SPARE_LAST  = '1;

    typedef struct packed {
        bit                 is_write;
        logic [IDX_W-1:0]   reg_idx;
        logic [DATA_W-1:0]  reg_val;
        sws_pkg::t_req      req;
        bit                 known;
        sws_pkg::t_res      want;
    } t_plan_row;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    sws_pkg::t_req      req_beat;
    logic               res_valid;
    logic               res_stall;
    sws_pkg::t_res      res_beat;
    logic               cfg_we;
    logic [IDX_W-1:0]   cfg_idx;
    logic [DATA_W-1:0]  cfg_data;

    // Limiter state as the predictor sees it; index 1 is the high-rate class.
    logic [31:0]  stamps [2][RING_DEPTH];
    int unsigned  oldest [2];
    int unsigned  fill [2];
    logic [7:0]   max_keep [2];
    logic [15:0]  min_spacing [2];
    logic [19:0]  window_len;
    logic [19:0]  holdoff_len;
    logic [31:0]  last_warn_at [2];
    bit           warned [2];

    sws_pkg::t_res pending [$];
    t_plan_row     plan [$];
    int            error_count = 0;
    bit            sender_idles = 1'b1;
    bit            receiver_idles = 1'b1;

    sliding_window_send_limiter u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_stall  (req_stall),
        .i_in_req    (req_beat),
        .o_out_valid (res_valid),
        .i_out_stall (res_stall),
        .o_out_res   (res_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic note_warning(input int kind, input logic [31:0] now);
        logic [31:0] since;
        since = now - last_warn_at[kind];
        if (!warned[kind] || since > holdoff_len) begin
            last_warn_at[kind] = now;
            warned[kind] = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic sws_pkg::t_res decide_send(input sws_pkg::t_req r);
        sws_pkg::t_res res;
        int unsigned   cls;
        int unsigned   cap;
        logic [31:0]   age;
        bit            too_fast;
        bit            aging;
        res = '0;
        res.refusal = sws_pkg::REFUSE_NONE;
        cls = {31'd0, r.high_rate};
        cap = (32'(max_keep[cls]) > RING_DEPTH) ? RING_DEPTH : 32'(max_keep[cls]);
        too_fast = 1'b0;
        if (fill[cls] != 0) begin
            age = r.now_ms - stamps[cls][(oldest[cls] + fill[cls] - 1) % RING_DEPTH];
            too_fast = (age < {16'd0, min_spacing[cls]});
        end
        if (too_fast) begin
            res.refusal = sws_pkg::REFUSE_FAST;
            res.warn = note_warning(KIND_FAST, r.now_ms);
        end else begin
            aging = 1'b1;
            while (aging && fill[cls] != 0) begin
                age = r.now_ms - stamps[cls][oldest[cls]];
                if (age > {12'd0, window_len}) begin
                    oldest[cls] = (oldest[cls] + 1) % RING_DEPTH;
                    fill[cls]--;
                end else begin
                    aging = 1'b0;
                end
            end
            if (fill[cls] >= cap) begin
                res.refusal = sws_pkg::REFUSE_MANY;
                res.warn = note_warning(KIND_MANY, r.now_ms);
            end else begin
                stamps[cls][(oldest[cls] + fill[cls]) % RING_DEPTH] = r.now_ms;
                fill[cls]++;
                res.accepted = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic void plan_write(input logic [IDX_W-1:0] idx,
                                       input logic [DATA_W-1:0] val);
        t_plan_row row;
        row = '0;
        row.is_write = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        plan.insert(plan.size(), row);
    endfunction

    function automatic void plan_send(input logic [31:0] now, input bit hi, input bit known,
                                      input logic acc, input logic [1:0] why, input logic wrn);
        t_plan_row row;
        row = '0;
        row.req.now_ms = now;
        row.req.high_rate = hi;
        row.known = known;
        row.want.accepted = acc;
        row.want.refusal = why;
        row.want.warn = wrn;
        plan.insert(plan.size(), row);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value(input int unsigned lo,
                                                     input int unsigned hi,
                                                     input int unsigned typ_lo,
                                                     input int unsigned typ_hi);
        case ($urandom_range(0, 7))
            0: return DATA_W'(lo);
            1: return DATA_W'(hi);
            default: return DATA_W'($urandom_range(typ_lo, typ_hi));
        endcase
    endfunction

    function automatic logic [31:0] next_time(input logic [31:0] t, input bit filling);
        if (filling) return t + $urandom_range(0, 2);
        case ($urandom_range(0, 19))
            0: return $urandom();
            1: return t - $urandom_range(1, 1000);
            2: return t + $urandom_range(0, 2000000);
            default: return t + $urandom_range(0, 400);
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [1:0] want,
                                        input logic [1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic push_req(input sws_pkg::t_req r, input bit known, input sws_pkg::t_res want);
        sws_pkg::t_res predicted;
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_beat  <= r;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        predicted = decide_send(r);
        pending.insert(pending.size(), known ? want : predicted);
        @(negedge clk);
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        while (pending.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        case (idx)
            sws_pkg::CFG_HIGH_MAX_COUNT:  max_keep[1] = val[7:0];
            sws_pkg::CFG_LOW_MAX_COUNT:   max_keep[0] = val[7:0];
            sws_pkg::CFG_HIGH_MIN_GAP_MS: min_spacing[1] = val[15:0];
            sws_pkg::CFG_LOW_MIN_GAP_MS:  min_spacing[0] = val[15:0];
            sws_pkg::CFG_WINDOW_MS:       window_len = val[19:0];
            sws_pkg::CFG_WARN_HOLDOFF_MS: holdoff_len = val[19:0];
            default: ;
        endcase
    endtask

    task automatic pick_settings(input bit filling);
        logic [DATA_W-1:0] noise;
        noise = DATA_W'($urandom());
        if (filling) begin
            // Counts at or above the ring depth, no spacing, nothing ages out.
            write_reg(sws_pkg::CFG_HIGH_MAX_COUNT, {noise[19:8], 8'd255});
            write_reg(sws_pkg::CFG_LOW_MAX_COUNT, {noise[19:8], 8'd128});
            write_reg(sws_pkg::CFG_HIGH_MIN_GAP_MS, {noise[19:16], 16'd0});
            write_reg(sws_pkg::CFG_LOW_MIN_GAP_MS, 20'd0);
            write_reg(sws_pkg::CFG_WINDOW_MS, 20'hFFFFF);
            write_reg(sws_pkg::CFG_WARN_HOLDOFF_MS, pick_value(0, 20'hFFFFF, 0, 2000));
        end else begin
            write_reg(sws_pkg::CFG_HIGH_MAX_COUNT,
                      pick_value(0, 255, 1, 8) | {noise[19:8], 8'd0});
            write_reg(sws_pkg::CFG_LOW_MAX_COUNT,
                      pick_value(0, 255, 1, 8) | {noise[11:0], 8'd0});
            write_reg(sws_pkg::CFG_HIGH_MIN_GAP_MS,
                      pick_value(0, 65535, 0, 300) | {noise[3:0], 16'd0});
            write_reg(sws_pkg::CFG_LOW_MIN_GAP_MS,
                      pick_value(0, 65535, 0, 300) | {noise[7:4], 16'd0});
            write_reg(sws_pkg::CFG_WINDOW_MS, pick_value(0, 20'hFFFFF, 50, 3000));
            write_reg(sws_pkg::CFG_WARN_HOLDOFF_MS, pick_value(0, 20'hFFFFF, 0, 2000));
        end
    endtask

    initial begin
        res_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (receiver_idles && $urandom_range(0, 7) == 0) begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        sws_pkg::t_res want;
        if (rst_n && res_valid && !res_stall) begin
            if (pending.size() == 0) begin
                $error("result beat with nothing outstanding: accepted %0d refusal %0d warn %0d",
                       res_beat.accepted, res_beat.refusal, res_beat.warn);
                error_count++;
            end else begin
                want = pending.pop_front();
                check_field("accepted", {1'b0, want.accepted}, {1'b0, res_beat.accepted});
                check_field("refusal", want.refusal, res_beat.refusal);
                check_field("warn", {1'b0, want.warn}, {1'b0, res_beat.warn});
            end
        end
    end

    initial begin
        sws_pkg::t_req r;
        logic [31:0]   clock_ms;
        bit            filling;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_beat  = '0;
        cfg_we    = 1'b0;
        cfg_idx   = '0;
        cfg_data  = '0;

        max_keep[1]    = sws_pkg::HIGH_MAX_COUNT_RST;
        max_keep[0]    = sws_pkg::LOW_MAX_COUNT_RST;
        min_spacing[1] = sws_pkg::HIGH_MIN_GAP_MS_RST;
        min_spacing[0] = sws_pkg::LOW_MIN_GAP_MS_RST;
        window_len     = sws_pkg::WINDOW_MS_RST;
        holdoff_len    = sws_pkg::WARN_HOLDOFF_MS_RST;
        for (int c = 0; c < 2; c++) begin
            oldest[c] = 0;
            fill[c] = 0;
            last_warn_at[c] = '0;
            warned[c] = 1'b0;
        end

        // Reset settings: spacing refusals, first warnings, exact gap boundary.
        plan_send(32'd0, 1'b1, 1'b1, 1'b1, sws_pkg::REFUSE_NONE, 1'b0);
        plan_send(32'd50, 1'b1, 1'b1, 1'b0, sws_pkg::REFUSE_FAST, 1'b1);
        plan_send(32'd60, 1'b1, 1'b1, 1'b0, sws_pkg::REFUSE_FAST, 1'b0);
        plan_send(32'd100, 1'b1, 1'b1, 1'b1, sws_pkg::REFUSE_NONE, 1'b0);
        plan_send(32'd100, 1'b0, 1'b1, 1'b1, sws_pkg::REFUSE_NONE, 1'b0);
        plan_send(32'd1199, 1'b0, 1'b1, 1'b0, sws_pkg::REFUSE_FAST, 1'b0);
        plan_write(CFG_SPARE_LAST, 20'hFFFFF);
        plan_write(CFG_SPARE_FIRST, 20'h00000);
        plan_send(32'd1200, 1'b0, 1'b1, 1'b1, sws_pkg::REFUSE_NONE, 1'b0);
        // A zero maximum refuses everything that passes the spacing test.
        plan_write(sws_pkg::CFG_LOW_MAX_COUNT, 20'd0);
        plan_send(32'd2400, 1'b0, 1'b1, 1'b0, sws_pkg::REFUSE_MANY, 1'b1);
        plan_send(32'd3600, 1'b0, 1'b1, 1'b0, sws_pkg::REFUSE_MANY, 1'b0);
        // Zero holdoff: a warning at the same millisecond is still held back.
        plan_write(sws_pkg::CFG_WARN_HOLDOFF_MS, 20'd0);
        plan_write(sws_pkg::CFG_WINDOW_MS, 20'd1);
        plan_send(32'd4800, 1'b0, 1'b1, 1'b0, sws_pkg::REFUSE_MANY, 1'b1);
        plan_send(32'd4800, 1'b0, 1'b1, 1'b0, sws_pkg::REFUSE_MANY, 1'b0);
        plan_write(sws_pkg::CFG_LOW_MAX_COUNT, 20'd255);
        plan_write(sws_pkg::CFG_LOW_MIN_GAP_MS, 20'd0);
        plan_write(sws_pkg::CFG_HIGH_MIN_GAP_MS, 20'd65535);
        plan_write(sws_pkg::CFG_WINDOW_MS, 20'hFFFFF);
        plan_write(sws_pkg::CFG_WARN_HOLDOFF_MS, 20'hFFFFF);
        plan_write(sws_pkg::CFG_HIGH_MAX_COUNT, 20'd128);
        // Timestamps across the 32-bit wrap and going backwards.
        plan_send(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, sws_pkg::REFUSE_NONE, 1'b0);
        plan_send(32'h0000_0000, 1'b1, 1'b1, 1'b0, sws_pkg::REFUSE_FAST, 1'b1);
        plan_send(32'h0000_FFFF, 1'b1, 1'b0, 1'b0, sws_pkg::REFUSE_NONE, 1'b0);
        plan_send(32'h8000_0000, 1'b0, 1'b0, 1'b0, sws_pkg::REFUSE_NONE, 1'b0);
        plan_send(32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, sws_pkg::REFUSE_NONE, 1'b0);
        plan_send(32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, sws_pkg::REFUSE_NONE, 1'b0);
        plan_write(sws_pkg::CFG_HIGH_MAX_COUNT, 20'd1);
        plan_write(sws_pkg::CFG_LOW_MIN_GAP_MS, 20'd65535);
        plan_send(32'h8001_0000, 1'b1, 1'b0, 1'b0, sws_pkg::REFUSE_NONE, 1'b0);
        plan_send(32'h8002_0000, 1'b1, 1'b0, 1'b0, sws_pkg::REFUSE_NONE, 1'b0);
        plan_send(32'h8002_0001, 1'b0, 1'b0, 1'b0, sws_pkg::REFUSE_NONE, 1'b0);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_write) begin
                drain_results();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                push_req(plan[i].req, plan[i].known, plan[i].want);
            end
        end

        // Each phase starts from an idle block with fresh settings. The fill phase
        // packs one class past the ring depth so the next phase can age it all out.
        clock_ms = 32'hFFFF_F000;
        for (int p = 0; p < PHASES; p++) begin
            filling = (p == FILL_PHASE);
            drain_results();
            sender_idles = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
            receiver_idles = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
            pick_settings(filling);
            for (int n = 0; n < (filling ? 150 : 36); n++) begin
                clock_ms = next_time(clock_ms, filling);
                r.now_ms = clock_ms;
                r.high_rate = filling ? ($urandom_range(0, 9) != 0) : 1'($urandom_range(0, 1));
                push_req(r, 1'b0, '0);
            end
        end

        drain_results();
        repeat (150) @(negedge clk);
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
